@@ sv/s2cd_pkg.sv @@
// ----------------------------------------------------------------------------
// s2cd_pkg
// Types, constants and helpers shared by the seconds-to-date converter.
// ----------------------------------------------------------------------------
package s2cd_pkg;

  localparam int unsigned BASE_YEAR   = 1900;
  localparam int unsigned LEAP_DAYS   = 366;
  localparam int unsigned COMMON_DAYS = 365;
  localparam int unsigned DIV_STEPS   = 2;  // reciprocal multiply, then quotient/remainder
  localparam int unsigned CNT_W       = $clog2(DIV_STEPS);
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
  localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
  // ceil(2^37 / 60) and ceil(2^36 / 24): exact for any 32-bit dividend
  localparam logic [31:0] RECIP_60    = 32'h8888_8889;
  localparam logic [31:0] RECIP_24    = 32'hAAAA_AAAB;
  localparam logic [3:0]  MONTH_LAST  = 4'd11;
  // 1900 mod 4, mod 100, mod 400
  localparam logic [1:0]  BASE_MOD4   = 2'd0;
  localparam logic [6:0]  BASE_MOD100 = 7'd0;
  localparam logic [8:0]  BASE_MOD400 = 9'd300;

  typedef struct packed {
    logic [31:0]        ntp_seconds;
    logic signed [15:0] offset_minutes;
  } s2cd_in_t;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } s2cd_out_t;

  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR
  } s2cd_div_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV_SEC,
    ST_DIV_MIN,
    ST_DIV_HOUR,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } s2cd_state_t;

  typedef struct packed {
    logic          load;
    logic          add;
    logic          div_step;
    logic          div_last;
    s2cd_div_sel_t div_sel;
    logic          year_step;
    logic          month_step;
  } s2cd_cmd_t;

  typedef struct packed {
    logic year_more;   // day count still covers the current year
    logic month_stop;  // day falls inside current month, or month is December
  } s2cd_sts_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    begin
      unique case (m)
        4'd0:    d = 5'd31;
        4'd1:    d = leap ? 5'd29 : 5'd28;
        4'd2:    d = 5'd31;
        4'd3:    d = 5'd30;
        4'd4:    d = 5'd31;
        4'd5:    d = 5'd30;
        4'd6:    d = 5'd31;
        4'd7:    d = 5'd31;
        4'd8:    d = 5'd30;
        4'd9:    d = 5'd31;
        4'd10:   d = 5'd30;
        4'd11:   d = 5'd31;
        default: d = 5'd31;
      endcase
      return d;
    end
  endfunction

endpackage

@@ sv/s2cd_ctrl.sv @@
// ----------------------------------------------------------------------------
// s2cd_ctrl
// Sequencer: offset add, three constant divisions, year walk, month walk.
// ----------------------------------------------------------------------------
module s2cd_ctrl
  import s2cd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output s2cd_cmd_t cmd,
  input  s2cd_sts_t sts
);

  s2cd_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last;

  assign last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd            = '0;
    cmd.div_sel    = DIV_SEC;
    busy           = 1'b1;
    out_valid      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV_SEC;
      end
      ST_DIV_SEC, ST_DIV_MIN, ST_DIV_HOUR: begin
        cmd.div_step = 1'b1;
        cmd.div_last = last;
        cmd.div_sel  = (state_r == ST_DIV_SEC) ? DIV_SEC :
                       (state_r == ST_DIV_MIN) ? DIV_MIN : DIV_HOUR;
        cnt_nxt      = cnt_r + 1'b1;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_DIV_SEC) ? ST_DIV_MIN :
                      (state_r == ST_DIV_MIN) ? ST_DIV_HOUR : ST_YEAR;
        end
      end
      ST_YEAR: begin
        cmd.year_step = 1'b1;
        if (!sts.year_more) state_nxt = ST_MONTH;
      end
      ST_MONTH: begin
        cmd.month_step = 1'b1;
        if (sts.month_stop) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ sv/s2cd_dp.sv @@
// ----------------------------------------------------------------------------
// s2cd_dp
// Datapath: offset adder, reciprocal constant divider, year and month counters.
// ----------------------------------------------------------------------------
module s2cd_dp
  import s2cd_pkg::*;
(
  input  logic      clk,
  input  s2cd_in_t  in_data,
  input  s2cd_cmd_t cmd,
  output s2cd_sts_t sts,
  output s2cd_out_t out_data
);

  logic [31:0]        secs_r;
  logic signed [15:0] off_r;
  logic [31:0]        acc_r;   // dividend in, quotient out
  logic [63:0]        prod_r;  // dividend times reciprocal
  logic [5:0]         sec_r, min_r;
  logic [4:0]         hour_r;
  logic [15:0]        days_r;
  logic [10:0]        year_r;
  logic [1:0]         y4_r;
  logic [6:0]         y100_r;
  logic [8:0]         y400_r;
  logic [3:0]         month_r;

  logic signed [21:0] off_secs;
  logic [31:0]        total;
  logic [5:0]         dvs;
  logic [31:0]        recip;
  logic [31:0]        quo;
  logic [5:0]         rem_nxt;
  logic               leap;
  logic [8:0]         ylen;
  logic [4:0]         mlen;

  assign off_secs = off_r * $signed(7'sd60);
  assign total    = secs_r + {{10{off_secs[21]}}, off_secs};

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SEC: begin
        dvs   = SECS_PER_MIN;
        recip = RECIP_60;
      end
      DIV_MIN: begin
        dvs   = MINS_PER_HOUR;
        recip = RECIP_60;
      end
      DIV_HOUR: begin
        dvs   = HOURS_PER_DAY;
        recip = RECIP_24;
      end
      default: begin
        dvs   = SECS_PER_MIN;
        recip = RECIP_60;
      end
    endcase
  end

  // quotient is the top of the product; remainder only needs the low six bits
  assign quo     = (cmd.div_sel == DIV_HOUR) ? {4'd0, prod_r[63:36]} : {5'd0, prod_r[63:37]};
  assign rem_nxt = acc_r[5:0] - 6'(quo[5:0] * dvs);

  assign leap     = (y4_r == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
  assign ylen     = leap ? 9'(LEAP_DAYS) : 9'(COMMON_DAYS);
  assign mlen     = month_days(month_r, leap);
  assign sts.year_more  = (days_r >= {7'd0, ylen});
  assign sts.month_stop = (days_r < {11'd0, mlen}) || (month_r == MONTH_LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs_r  <= in_data.ntp_seconds;
      off_r   <= in_data.offset_minutes;
      year_r  <= 11'(BASE_YEAR);
      y4_r    <= BASE_MOD4;
      y100_r  <= BASE_MOD100;
      y400_r  <= BASE_MOD400;
      month_r <= '0;
    end
    if (cmd.add) begin
      acc_r <= total;
    end
    if (cmd.div_step) begin
      if (!cmd.div_last) begin
        prod_r <= acc_r * recip;
      end else begin
        acc_r <= quo;
        unique case (cmd.div_sel)
          DIV_SEC:  sec_r  <= rem_nxt;
          DIV_MIN:  min_r  <= rem_nxt;
          DIV_HOUR: begin
            hour_r <= rem_nxt[4:0];
            days_r <= quo[15:0];
          end
          default:  sec_r  <= rem_nxt;
        endcase
      end
    end
    if (cmd.year_step && sts.year_more) begin
      days_r <= days_r - {7'd0, ylen};
      year_r <= year_r + 1'b1;
      y4_r   <= y4_r + 1'b1;
      y100_r <= (y100_r == 7'd99)  ? 7'd0 : y100_r + 1'b1;
      y400_r <= (y400_r == 9'd399) ? 9'd0 : y400_r + 1'b1;
    end
    if (cmd.month_step && !sts.month_stop) begin
      days_r  <= days_r - {11'd0, mlen};
      month_r <= month_r + 1'b1;
    end
  end

  assign out_data.year   = year_r;
  assign out_data.month  = month_r + 1'b1;
  assign out_data.day    = days_r[4:0] + 1'b1;
  assign out_data.hour   = hour_r;
  assign out_data.minute = min_r;
  assign out_data.second = sec_r;

endmodule

@@ sv/seconds_to_calendar_date.sv @@
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Seconds since 1900 plus local offset -> Gregorian date and time of day.
// ----------------------------------------------------------------------------
//  channel | ports                     | handshake
//  --------+---------------------------+---------------------------------
//  input   | start, busy, in_data      | beat taken when start && !busy
//  result  | out_valid, out_data       | one-cycle strobe, no backpressure
//
//  Each of the three divisions is a reciprocal multiply followed by a
//  quotient and remainder step, then the year and month walks subtract one
//  unit per cycle. busy is low only while the sequencer is idle and high
//  through the result strobe; one beat at a time. Synchronous active-low
//  reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date
  import s2cd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  s2cd_in_t  in_data,
  output logic      out_valid,
  output s2cd_out_t out_data
);

  s2cd_cmd_t cmd;
  s2cd_sts_t sts;

  s2cd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  s2cd_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
